// ===== rtl/ppc_pkg.sv =====
// ppc_pkg: shared types and constants for the pedal position conditioner.
// Holds register indexes, configuration struct and controller/datapath
// command and status structs. No dependencies.
package ppc_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_SMOOTH_ENABLE = 3'd0;
  localparam logic [2:0] CFG_START_CODE    = 3'd1;
  localparam logic [2:0] CFG_ANGLE_GAIN    = 3'd2;
  localparam logic [2:0] CFG_PEDAL_ZERO    = 3'd3;
  localparam logic [2:0] CFG_REGEN_GAIN    = 3'd4;
  localparam logic [2:0] CFG_DRIVE_GAIN    = 3'd5;
  localparam logic [2:0] CFG_LOW_CODE      = 3'd6;
  localparam logic [2:0] CFG_HIGH_CODE     = 3'd7;

  // Reset values of the registers
  localparam logic        RST_SMOOTH_ENABLE = 1'b1;
  localparam logic [11:0] RST_START_CODE    = 12'd410;
  localparam logic [15:0] RST_ANGLE_GAIN    = 16'd256;
  localparam logic [15:0] RST_PEDAL_ZERO    = 16'd0;
  localparam logic [15:0] RST_REGEN_GAIN    = 16'd256;
  localparam logic [15:0] RST_DRIVE_GAIN    = 16'd256;
  localparam logic [11:0] RST_LOW_CODE      = 12'd200;
  localparam logic [11:0] RST_HIGH_CODE     = 12'd3900;

  // Q1.15 limits used by the fraction clamps, and the angle saturation limits
  localparam logic [15:0] FRAC_NEG_ONE = 16'h8000;
  localparam logic [15:0] FRAC_POS_ONE = 16'h8000;
  localparam logic [15:0] FRAC_ZERO    = 16'h0000;
  localparam logic [15:0] ANGLE_MAX    = 16'h7fff;
  localparam logic [15:0] ANGLE_MIN    = 16'h8000;

  // Datapath settings (smoothing flag is consumed by the controller)
  typedef struct packed {
    logic [11:0]        start_code;
    logic [15:0]        angle_gain;
    logic signed [15:0] pedal_zero;
    logic [15:0]        regen_gain;
    logic [15:0]        drive_gain;
    logic [11:0]        low_code;
    logic [11:0]        high_code;
  } cfg_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic take;       // item accepted: latch sample, read ring slot
    logic raw_level;  // with take: level is the raw sample
    logic sum_upd;    // update running sum, write ring, advance slot
    logic div_mul;    // sum times reciprocal of window
    logic lvl_load;   // level from reciprocal product
    logic ang_mul;    // (level - start) * angle gain
    logic ang_sat;    // shift, subtract zero, saturate
    logic frac_mul;   // angle times regen and drive gains
    logic out_load;   // clamp fractions into output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic out_free;   // output register can take a new result
  } stat_t;

endpackage

// ===== rtl/ppc_ctrl.sv =====
// ppc_ctrl: sequencing state machine of the pedal position conditioner.
// One command a cycle to ppc_datapath unless stalled; needs ppc_pkg.
module ppc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           smooth_enable,
  input  ppc_pkg::stat_t stat,
  output ppc_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_SUM  = 8'b00000010,
    ST_DIV  = 8'b00000100,
    ST_LVL  = 8'b00001000,
    ST_ANG  = 8'b00010000,
    ST_SAT  = 8'b00100000,
    ST_FRAC = 8'b01000000,
    ST_OUT  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign in_stall = (state_r != ST_IDLE);
  assign take     = in_valid && (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          cmd.take      = 1'b1;
          cmd.raw_level = !smooth_enable;
          state_nxt     = smooth_enable ? ST_SUM : ST_ANG;
        end
      end
      ST_SUM: begin
        cmd.sum_upd = 1'b1;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_mul = 1'b1;
        state_nxt   = ST_LVL;
      end
      ST_LVL: begin
        cmd.lvl_load = 1'b1;
        state_nxt    = ST_ANG;
      end
      ST_ANG: begin
        cmd.ang_mul = 1'b1;
        state_nxt   = ST_SAT;
      end
      ST_SAT: begin
        cmd.ang_sat = 1'b1;
        state_nxt   = ST_FRAC;
      end
      ST_FRAC: begin
        cmd.frac_mul = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        // wait here while the previous result is still held
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // One item at a time: an accepted item blocks the input next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an item was taken");

  // A result is only loaded when the output register is free
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("output loaded while previous result still held");

endmodule

// ===== rtl/ppc_datapath.sv =====
// ppc_datapath: sample ring, running sum, reciprocal divide, angle and
// fraction arithmetic and the output register. Driven by ppc_ctrl commands.
// Depends on ppc_pkg.
module ppc_datapath #(
  parameter int WINDOW      = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ppc_pkg::cmd_t       cmd,
  output ppc_pkg::stat_t      stat,
  input  ppc_pkg::cfg_t       cfg,
  input  logic [11:0]         in_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [11:0]         out_level,
  output logic signed [15:0]  out_angle,
  output logic signed [15:0]  out_regen_fraction,
  output logic [15:0]         out_drive_fraction,
  output logic                out_connected
);

  localparam int AW        = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW);
  localparam int LVL_W     = SAMPLE_BITS;
  // floor(x / WINDOW) = (x * DIV_M) >> DIV_SHIFT for every x below 2^SUM_W
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int M_W       = SUM_W + 1;
  localparam logic [63:0] DIV_M_FULL =
    ((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [M_W-1:0] DIV_M = DIV_M_FULL[M_W-1:0];
  localparam int PROD_W    = SUM_W + M_W;
  localparam int CMP_W     = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
  localparam int DIFF_W    = CMP_W + 1;
  localparam int ANGP_W    = DIFF_W + 17;
  localparam int A1_W      = ANGP_W - 8;
  localparam int A2_W      = A1_W + 1;
  localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW - 1);
  localparam logic [15:0] ANGLE_MAX_L = ppc_pkg::ANGLE_MAX;
  localparam logic [15:0] ANGLE_MIN_L = ppc_pkg::ANGLE_MIN;

  // Ring storage and sum state
  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];
  logic [WINDOW-1:0]      ring_vld_r;
  logic [SAMPLE_BITS-1:0] ring_rd_r;
  logic [AW-1:0]          slot_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;
  logic [SAMPLE_BITS-1:0] old_smp;

  // Pipeline payload
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [PROD_W-1:0]      div_prod_r;
  logic [LVL_W-1:0]       level_r;
  logic signed [ANGP_W-1:0] angp_r;
  logic signed [15:0]     ang_r;
  logic signed [32:0]     regen_p_r;
  logic signed [32:0]     drive_p_r;

  logic [SAMPLE_BITS-1:0] smp;
  logic [CMP_W-1:0]       level_x;
  logic [CMP_W-1:0]       start_x;
  logic signed [DIFF_W-1:0] diff;
  logic signed [ANGP_W-1:0] angp;
  logic signed [A1_W-1:0] a1;
  logic signed [A2_W-1:0] a2;
  logic [15:0]            ang_sat;
  logic signed [24:0]     r1;
  logic signed [24:0]     d1;
  logic [15:0]            regen_c;
  logic [15:0]            drive_c;
  logic                   conn;
  logic                   out_valid_r;

  assign smp = SAMPLE_BITS'(in_sample);

  // Running sum: drop the oldest sample, add the new one
  assign old_smp = ring_vld_r[slot_r] ? ring_rd_r : '0;
  assign sum_nxt = sum_r - SUM_W'(old_smp) + SUM_W'(sample_r);

  // Ring memory: registered read at take, write at sum update
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ring_rd_r <= ring_mem[slot_r];
    end
    if (cmd.sum_upd) begin
      ring_mem[slot_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      slot_r     <= '0;
      sum_r      <= '0;
    end else if (cmd.sum_upd) begin
      ring_vld_r[slot_r] <= 1'b1;
      slot_r             <= (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
      sum_r              <= sum_nxt;
    end
  end

  // Angle: (level - start) * gain, then floor >> 8, minus zero, saturate
  assign level_x = CMP_W'(level_r);
  assign start_x = CMP_W'(cfg.start_code);
  assign diff    = $signed({1'b0, level_x}) - $signed({1'b0, start_x});
  assign angp    = diff * $signed({1'b0, cfg.angle_gain});
  assign a1      = angp_r[ANGP_W-1:8];
  assign a2      = A2_W'(a1) - A2_W'(cfg.pedal_zero);

  always_comb begin
    if (!a2[A2_W-1] && (|a2[A2_W-2:15])) begin
      ang_sat = ANGLE_MAX_L;
    end else if (a2[A2_W-1] && !(&a2[A2_W-2:15])) begin
      ang_sat = ANGLE_MIN_L;
    end else begin
      ang_sat = a2[15:0];
    end
  end

  // Fractions: floor >> 8 of products, clamped to Q1.15 regen, UQ1.15 drive
  assign r1 = regen_p_r[32:8];
  assign d1 = drive_p_r[32:8];

  always_comb begin
    if (!r1[24]) begin
      regen_c = ppc_pkg::FRAC_ZERO;
    end else if (!(&r1[23:15])) begin
      regen_c = ppc_pkg::FRAC_NEG_ONE;
    end else begin
      regen_c = r1[15:0];
    end
    if (d1[24]) begin
      drive_c = ppc_pkg::FRAC_ZERO;
    end else if (|d1[23:15]) begin
      drive_c = ppc_pkg::FRAC_POS_ONE;
    end else begin
      drive_c = d1[15:0];
    end
  end

  assign conn = (level_x > CMP_W'(cfg.low_code)) && (level_x < CMP_W'(cfg.high_code));

  // Arithmetic stages, each behind its own register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sample_r <= smp;
      if (cmd.raw_level) begin
        level_r <= LVL_W'(smp);
      end
    end
    if (cmd.div_mul) begin
      div_prod_r <= PROD_W'(sum_r) * PROD_W'(DIV_M);
    end
    if (cmd.lvl_load) begin
      level_r <= div_prod_r[DIV_SHIFT +: LVL_W];
    end
    if (cmd.ang_mul) begin
      angp_r <= angp;
    end
    if (cmd.ang_sat) begin
      ang_r <= $signed(ang_sat);
    end
    if (cmd.frac_mul) begin
      regen_p_r <= ang_r * $signed({1'b0, cfg.regen_gain});
      drive_p_r <= ang_r * $signed({1'b0, cfg.drive_gain});
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_level          <= 12'(level_r);
      out_angle          <= ang_r;
      out_regen_fraction <= $signed(regen_c);
      out_drive_fraction <= drive_c;
      out_connected      <= conn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  // Each ring update moves to a new slot
  a_slot_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum_upd |=> (slot_r != $past(slot_r)))
    else $error("ring slot did not advance");

  // Held fractions stay inside their clamp ranges
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_drive_fraction <= ppc_pkg::FRAC_POS_ONE) &&
                    (out_regen_fraction <= 16'sd0))
    else $error("fraction outside clamp range");

endmodule

// ===== rtl/pedal_position_conditioner.sv =====
// pedal_position_conditioner: top level with configuration registers,
// controller and datapath. Depends on ppc_pkg, ppc_ctrl and ppc_datapath.
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | in_sample[11:0]
//  out_    | output    | out_valid/out_stall | level, angle, regen/drive fraction, connected
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index[2:0], cfg_data[15:0]
//
// One item at a time: with smoothing on, an accepted item passes through
// sum update, reciprocal multiply, level, angle multiply, saturate,
// fraction multiplies and output load; with smoothing off it starts at
// the angle multiply. The next item is taken the cycle after the result
// is loaded into the output register.
// A stalled output holds the controller in its last state until it drains.
// Reset (rst_n low, synchronous) clears the ring valid bits, sum and slot
// at once and loads the register defaults; no clearing pass is needed.
module pedal_position_conditioner #(
  parameter int WINDOW      = 8,
  parameter int SAMPLE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_level,
  output logic signed [15:0] out_angle,
  output logic signed [15:0] out_regen_fraction,
  output logic [15:0]        out_drive_fraction,
  output logic               out_connected,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic           smooth_enable_r;
  ppc_pkg::cfg_t  cfg_r;
  ppc_pkg::cmd_t  cmd;
  ppc_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_enable_r  <= ppc_pkg::RST_SMOOTH_ENABLE;
      cfg_r.start_code <= ppc_pkg::RST_START_CODE;
      cfg_r.angle_gain <= ppc_pkg::RST_ANGLE_GAIN;
      cfg_r.pedal_zero <= ppc_pkg::RST_PEDAL_ZERO;
      cfg_r.regen_gain <= ppc_pkg::RST_REGEN_GAIN;
      cfg_r.drive_gain <= ppc_pkg::RST_DRIVE_GAIN;
      cfg_r.low_code   <= ppc_pkg::RST_LOW_CODE;
      cfg_r.high_code  <= ppc_pkg::RST_HIGH_CODE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ppc_pkg::CFG_SMOOTH_ENABLE: smooth_enable_r  <= cfg_data[0];
        ppc_pkg::CFG_START_CODE:    cfg_r.start_code <= cfg_data[11:0];
        ppc_pkg::CFG_ANGLE_GAIN:    cfg_r.angle_gain <= cfg_data;
        ppc_pkg::CFG_PEDAL_ZERO:    cfg_r.pedal_zero <= $signed(cfg_data);
        ppc_pkg::CFG_REGEN_GAIN:    cfg_r.regen_gain <= cfg_data;
        ppc_pkg::CFG_DRIVE_GAIN:    cfg_r.drive_gain <= cfg_data;
        ppc_pkg::CFG_LOW_CODE:      cfg_r.low_code   <= cfg_data[11:0];
        ppc_pkg::CFG_HIGH_CODE:     cfg_r.high_code  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  ppc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .smooth_enable (smooth_enable_r),
    .stat          (stat),
    .cmd           (cmd)
  );

  ppc_datapath #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg                (cfg_r),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_level          (out_level),
    .out_angle          (out_angle),
    .out_regen_fraction (out_regen_fraction),
    .out_drive_fraction (out_drive_fraction),
    .out_connected      (out_connected)
  );

endmodule

// ===== tb/sv/ppc_scoreboard_pkg.sv =====
// ppc_scoreboard_pkg: result type and scoreboard for the pedal position
// conditioner testbench; predicts level, angle, fractions and connected flag.
// Depends on ppc_pkg for register indexes, reset values and cfg_t.
package ppc_scoreboard_pkg;
  import ppc_pkg::*;

  typedef struct packed {
    logic [11:0]        level;
    logic signed [15:0] angle;
    logic signed [15:0] regen_fraction;
    logic [15:0]        drive_fraction;
    logic               connected;
  } pedal_result_t;

  class pedal_scoreboard;
    cfg_t          cfg;
    logic          smooth_on;
    logic [11:0]   ring [8];
    logic [14:0]   ring_sum;
    logic [2:0]    ring_slot;
    pedal_result_t expected_q [$];
    int unsigned   mismatches;
    int unsigned   samples_noted;
    int unsigned   results_checked;

    function new();
      smooth_on      = RST_SMOOTH_ENABLE;
      cfg.start_code = RST_START_CODE;
      cfg.angle_gain = RST_ANGLE_GAIN;
      cfg.pedal_zero = RST_PEDAL_ZERO;
      cfg.regen_gain = RST_REGEN_GAIN;
      cfg.drive_gain = RST_DRIVE_GAIN;
      cfg.low_code   = RST_LOW_CODE;
      cfg.high_code  = RST_HIGH_CODE;
      foreach (ring[i]) ring[i] = '0;
      ring_sum        = '0;
      ring_slot       = '0;
      mismatches      = 0;
      samples_noted   = 0;
      results_checked = 0;
    endfunction

    // mirror of a register write accepted by the block
    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_SMOOTH_ENABLE: smooth_on      = data[0];
        CFG_START_CODE:    cfg.start_code = data[11:0];
        CFG_ANGLE_GAIN:    cfg.angle_gain = data;
        CFG_PEDAL_ZERO:    cfg.pedal_zero = data;
        CFG_REGEN_GAIN:    cfg.regen_gain = data;
        CFG_DRIVE_GAIN:    cfg.drive_gain = data;
        CFG_LOW_CODE:      cfg.low_code   = data[11:0];
        CFG_HIGH_CODE:     cfg.high_code  = data[11:0];
        default: ;
      endcase
    endfunction

    static function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // advance the window (when smoothing) and work out all outputs of one sample
    function pedal_result_t condition(logic [11:0] s);
      pedal_result_t r;
      logic [11:0]   lvl;
      longint        ang;
      longint        regen;
      longint        drive;
      if (smooth_on) begin
        ring_sum        = ring_sum - ring[ring_slot] + s;
        ring[ring_slot] = s;
        ring_slot       = ring_slot + 3'd1;
        lvl             = ring_sum[14:3];  // floor of sum over the 8-deep window
      end else begin
        lvl = s;
      end
      // arithmetic shifts give floor for negative products
      ang   = ((longint'(lvl) - longint'(cfg.start_code)) * longint'(cfg.angle_gain)) >>> 8;
      ang   = clamp(ang - longint'($signed(cfg.pedal_zero)), -32768, 32767);
      regen = clamp((ang * longint'(cfg.regen_gain)) >>> 8, -32768, 0);
      drive = clamp((ang * longint'(cfg.drive_gain)) >>> 8, 0, 32768);
      r.level          = lvl;
      r.angle          = ang[15:0];
      r.regen_fraction = regen[15:0];
      r.drive_fraction = drive[15:0];
      r.connected      = (lvl > cfg.low_code) && (lvl < cfg.high_code);
      return r;
    endfunction

    // called when the block accepts a sample
    function void note_sample(logic [11:0] s);
      expected_q.push_back(condition(s));
      samples_noted++;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 50) $display("mismatch: %s", msg);
    endtask

    // called when the block hands over a result
    task check_result(pedal_result_t got);
      pedal_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending, level %0d", got.level));
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (got.level !== want.level)
        report($sformatf("result %0d level %0d, want %0d",
                         results_checked, got.level, want.level));
      if (got.angle !== want.angle)
        report($sformatf("result %0d angle %0d, want %0d",
                         results_checked, got.angle, want.angle));
      if (got.regen_fraction !== want.regen_fraction)
        report($sformatf("result %0d regen %0d, want %0d",
                         results_checked, got.regen_fraction, want.regen_fraction));
      if (got.drive_fraction !== want.drive_fraction)
        report($sformatf("result %0d drive %0d, want %0d",
                         results_checked, got.drive_fraction, want.drive_fraction));
      if (got.connected !== want.connected)
        report($sformatf("result %0d connected %b, want %b",
                         results_checked, got.connected, want.connected));
    endtask
  endclass

endpackage

// ===== tb/sv/pedal_position_conditioner_tb.sv =====
// pedal_position_conditioner_tb: drives samples and register writes into the
// conditioner and checks every result. Depends on ppc_pkg and ppc_scoreboard_pkg.
module pedal_position_conditioner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppc_pkg::*;
  import ppc_scoreboard_pkg::*;

  localparam int RAND_PHASES    = 10;
  localparam int RAND_PER_PHASE = 85;
  localparam int CLEAN_PHASE    = 3;
  localparam int HOLD_PHASE     = 6;
  localparam int HOLD_CYCLES    = 80;
  localparam int TAIL_CYCLES    = 20;
  localparam int LIMIT_CYCLES   = 200000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [11:0]        in_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [11:0]        out_level;
  logic signed [15:0] out_angle;
  logic signed [15:0] out_regen_fraction;
  logic [15:0]        out_drive_fraction;
  logic               out_connected;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data  = '0;

  logic               gaps_on   = 1'b1;
  logic               hold_kick = 1'b0;
  int unsigned        hold_left = 0;
  int unsigned        cycle_count = 0;
  int unsigned        phases_run = 0;
  logic [15:0]        setting [8];
  pedal_result_t      seen;
  pedal_scoreboard    sb;

  always #5 clk = ~clk;

  pedal_position_conditioner DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_level          (out_level),
    .out_angle          (out_angle),
    .out_regen_fraction (out_regen_fraction),
    .out_drive_fraction (out_drive_fraction),
    .out_connected      (out_connected),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // cycle budget
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: check accepted results, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.level          = out_level;
      seen.angle          = out_angle;
      seen.regen_fraction = out_regen_fraction;
      seen.drive_fraction = out_drive_fraction;
      seen.connected      = out_connected;
      sb.check_result(seen);
    end
    if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= gaps_on && ($urandom_range(99) < 18);
    end
  end

  // offer one sample; valid stays high after acceptance for the next item
  task automatic offer_sample(input logic [11:0] s);
    if (gaps_on && $urandom_range(99) < 18) begin
      in_valid  <= 1'b0;
      in_sample <= 12'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // write the whole register set from setting[]
  task automatic load_settings();
    for (int i = 0; i < 8; i++) write_reg(3'(i), setting[i]);
    cfg_valid <= 1'b0;
    phases_run++;
  endtask

  // stop offering and let every pending result drain
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_setting(input logic [2:0] idx);
    int unsigned roll;
    roll = $urandom_range(99);
    case (idx)
      CFG_SMOOTH_ENABLE: return {15'd0, roll < 75};
      CFG_START_CODE:
        return roll < 10 ? 16'd0 : roll < 20 ? 16'd4095 : 16'($urandom_range(0, 4095));
      CFG_ANGLE_GAIN:
        return roll < 10 ? 16'd0 : roll < 20 ? 16'hffff :
               roll < 40 ? 16'($urandom) : 16'($urandom_range(0, 1023));
      CFG_PEDAL_ZERO:
        return roll < 10 ? 16'h8000 : roll < 20 ? 16'h7fff :
               roll < 40 ? 16'($urandom) : 16'($urandom_range(0, 4095) - 2048);
      CFG_REGEN_GAIN, CFG_DRIVE_GAIN:
        return roll < 10 ? 16'd0 : roll < 20 ? 16'hffff :
               roll < 40 ? 16'($urandom) : 16'($urandom_range(0, 16383));
      CFG_LOW_CODE:
        return roll < 10 ? 16'd0 : roll < 20 ? 16'd4095 : 16'($urandom_range(0, 1200));
      CFG_HIGH_CODE:
        return roll < 10 ? 16'd0 : roll < 20 ? 16'd4095 : 16'($urandom_range(2800, 4095));
      default: return '0;
    endcase
  endfunction

  // mostly uniform, with extremes and codes near the angle zero and thresholds
  function automatic logic [11:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8)  return 12'h000;
    if (roll < 16) return 12'hfff;
    if (roll < 28) return 12'(sb.cfg.start_code + $urandom_range(0, 64) - 32);
    if (roll < 34) return 12'(sb.cfg.low_code + $urandom_range(0, 4) - 2);
    if (roll < 40) return 12'(sb.cfg.high_code + $urandom_range(0, 4) - 2);
    return 12'($urandom);
  endfunction

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: ring filling from zeros, then a drop
    for (int i = 0; i < 6; i++) offer_sample(12'hfff);
    offer_sample(12'h000);
    offer_sample(12'h800);
    wait_drained();

    // raw samples, full gains, most negative zero: positive saturation,
    // crossed thresholds
    setting[CFG_SMOOTH_ENABLE] = 16'd0;
    setting[CFG_START_CODE]    = 16'd0;
    setting[CFG_ANGLE_GAIN]    = 16'hffff;
    setting[CFG_PEDAL_ZERO]    = 16'h8000;
    setting[CFG_REGEN_GAIN]    = 16'hffff;
    setting[CFG_DRIVE_GAIN]    = 16'hffff;
    setting[CFG_LOW_CODE]      = 16'd4095;
    setting[CFG_HIGH_CODE]     = 16'd0;
    load_settings();
    offer_sample(12'hfff);
    offer_sample(12'h000);
    offer_sample(12'haaa);
    offer_sample(12'h555);
    wait_drained();

    // raw samples, start at full scale: negative saturation, regen clamp
    setting[CFG_START_CODE]    = 16'd4095;
    setting[CFG_PEDAL_ZERO]    = 16'h7fff;
    setting[CFG_DRIVE_GAIN]    = 16'd0;
    setting[CFG_LOW_CODE]      = 16'd0;
    setting[CFG_HIGH_CODE]     = 16'd4095;
    load_settings();
    offer_sample(12'h000);
    offer_sample(12'hfff);
    offer_sample(12'h001);
    offer_sample(12'h800);
    wait_drained();

    // smoothing back on: ring must still hold what it had before raw mode
    setting[CFG_SMOOTH_ENABLE] = 16'd1;
    setting[CFG_START_CODE]    = 16'd2048;
    setting[CFG_ANGLE_GAIN]    = 16'd256;
    setting[CFG_PEDAL_ZERO]    = 16'hffc0;
    setting[CFG_REGEN_GAIN]    = 16'd512;
    setting[CFG_DRIVE_GAIN]    = 16'd300;
    setting[CFG_LOW_CODE]      = 16'd100;
    setting[CFG_HIGH_CODE]     = 16'd4000;
    load_settings();
    offer_sample(12'h800);
    offer_sample(12'h7ff);
    offer_sample(12'h000);
    offer_sample(12'hfff);
    wait_drained();

    // random settings phases; one with no idling, one with a long output hold
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      gaps_on <= (ph != CLEAN_PHASE);
      for (int i = 0; i < 8; i++) setting[i] = pick_setting(3'(i));
      load_settings();
      if (ph == HOLD_PHASE) begin
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
      for (int n = 0; n < RAND_PER_PHASE; n++) offer_sample(pick_sample());
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d samples conditioned under %0d register settings, %0d results checked",
             sb.samples_noted, phases_run + 1, sb.results_checked);
    $display("included ring fill, raw mode, angle and fraction clamps, crossed thresholds");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
